/* hdl/pem_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants of the periodic event merger.
// ----------------------------------------------------------------------------
package pem_pkg;

   localparam int PER_W           = 16;
   localparam int TIME_W          = 32;
   localparam int OUT_IDX_W       = 10;
   localparam int MAX_SOURCES_DEF = 1024;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_POP   = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [PER_W-1:0] period;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]    event_time;
      logic [OUT_IDX_W-1:0] source_index;
      logic                 overflow;
      logic                 empty_res;
   } rsp_type;

   // write side of the source table
   typedef struct packed {
      logic              due_we;
      logic              per_we;
      logic [TIME_W-1:0] due;
      logic [PER_W-1:0]  per;
   } pem_wr_type;

endpackage

`default_nettype wire

/* hdl/pem_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pem_mem
// Source table: period and next due time per source, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module pem_mem
   import pem_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF,
   localparam int IDX_W = $clog2(MAX_SOURCES)
) (
   input  wire logic              clock,
   input  wire pem_wr_type        wr,
   input  wire logic [IDX_W-1:0]  waddr,
   input  wire logic [IDX_W-1:0]  raddr,
   output logic      [TIME_W-1:0] rd_due,
   output logic      [PER_W-1:0]  rd_per
);

   logic [TIME_W-1:0] due_mem_ff [MAX_SOURCES];
   logic [PER_W-1:0]  per_mem_ff [MAX_SOURCES];
   logic [TIME_W-1:0] rd_due_ff;
   logic [PER_W-1:0]  rd_per_ff;

   always_ff @(posedge clock) begin
      if (wr.due_we) begin
         due_mem_ff[waddr] <= wr.due;
      end
      if (wr.per_we) begin
         per_mem_ff[waddr] <= wr.per;
      end
      rd_due_ff <= due_mem_ff[raddr];
      rd_per_ff <= per_mem_ff[raddr];
   end

   assign rd_due = rd_due_ff;
   assign rd_per = rd_per_ff;

endmodule

`default_nettype wire

/* hdl/pem_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pem_ctrl
// Sequencer: decodes items, walks the table with one compare unit to find the
// earliest due time, then advances the winner by its period.
// ----------------------------------------------------------------------------
module pem_ctrl
   import pem_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF,
   localparam int IDX_W = $clog2(MAX_SOURCES),
   localparam int CNT_W = $clog2(MAX_SOURCES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   res_valid,
   input  wire logic              res_take,
   output rsp_type                res_data,
   output pem_wr_type             mem_wr,
   output logic      [IDX_W-1:0]  mem_waddr,
   output logic      [IDX_W-1:0]  mem_raddr,
   input  wire logic [TIME_W-1:0] rd_due,
   input  wire logic [PER_W-1:0]  rd_per
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [TIME_W-1:0] best_due_ff, best_due_in;
   logic [PER_W-1:0]  best_per_ff, best_per_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   rsp_type           res_ff, res_in;

   logic              accept;
   logic              full;
   logic              issue;
   logic              take_new;
   logic [TIME_W:0]   sum;
   logic              sum_ovf;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(MAX_SOURCES));
   assign issue     = (rd_idx_ff != count_ff);
   // first entry seeds the minimum; strict compare keeps the lower index on ties
   assign take_new  = cmp_valid_ff && ((cmp_idx_ff == '0) || (rd_due < best_due_ff));
   assign sum       = {1'b0, best_due_ff} + {{(TIME_W + 1 - PER_W){1'b0}}, best_per_ff};
   assign sum_ovf   = sum[TIME_W];

   assign mem_raddr = rd_idx_ff[IDX_W-1:0];
   assign res_valid = (state_ff == ST_EMIT);
   assign res_data  = res_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      best_due_in  = best_due_ff;
      best_per_in  = best_per_ff;
      best_idx_in  = best_idx_ff;
      res_in       = res_ff;
      mem_wr       = '0;
      mem_waddr    = count_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LOAD: begin
                     if (full) begin
                        res_in   = '0;
                        res_in.overflow = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        mem_wr.due_we = 1'b1;
                        mem_wr.per_we = 1'b1;
                        mem_wr.due    = TIME_W'(req_data.period);
                        mem_wr.per    = req_data.period;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_in   = '0;
                        res_in.empty_res = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        rd_idx_in = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
            end else begin
               // last compare lands this cycle
               state_in = ST_UPDATE;
            end
            if (take_new) begin
               best_due_in = rd_due;
               best_per_in = rd_per;
               best_idx_in = cmp_idx_ff;
            end
         end
         ST_UPDATE: begin
            mem_wr.due_we = 1'b1;
            mem_wr.due    = sum_ovf ? '1 : sum[TIME_W-1:0];
            mem_waddr     = best_idx_ff;
            res_in.event_time   = best_due_ff;
            res_in.source_index = OUT_IDX_W'(best_idx_ff);
            res_in.overflow     = sum_ovf;
            res_in.empty_res    = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      cmp_idx_ff  <= cmp_idx_in;
      best_due_ff <= best_due_in;
      best_per_ff <= best_per_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
   end

endmodule

`default_nettype wire

/* hdl/periodic_event_merger.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_event_merger
// Merges the event streams of up to MAX_SOURCES periodic sources.
// ----------------------------------------------------------------------------
// Clear, no-op and load-with-room items complete in the idle state. A
// full-table load or a pop on an empty table goes to the emit state with a
// flag result. A pop walks the table: a single comparator reads one due time
// per cycle from the source table memory to find the earliest event, then the
// update state advances the winner by its period and the emit state hands the
// item to the output register. The block takes no new item during a pop. A
// result waiting in the output register does not stall clear, no-op or load-with-room items.
module periodic_event_merger
   import pem_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(MAX_SOURCES);

   pem_wr_type        mem_wr;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_raddr;
   logic [TIME_W-1:0] rd_due;
   logic [PER_W-1:0]  rd_per;
   logic              res_valid;
   logic              res_take;
   rsp_type           res_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   pem_ctrl #(
      .MAX_SOURCES (MAX_SOURCES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mem_wr    (mem_wr),
      .mem_waddr (mem_waddr),
      .mem_raddr (mem_raddr),
      .rd_due    (rd_due),
      .rd_per    (rd_per)
   );

   pem_mem #(
      .MAX_SOURCES (MAX_SOURCES)
   ) u_mem (
      .clock  (clock),
      .wr     (mem_wr),
      .waddr  (mem_waddr),
      .raddr  (mem_raddr),
      .rd_due (rd_due),
      .rd_per (rd_per)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/pem_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pem_checker
// Port-level checks of the periodic event merger, bound to the top level.
// ----------------------------------------------------------------------------
module pem_checker
   import pem_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.overflow && rsp_data.empty_res))
      else $error("overflow and empty both set");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |->
         rsp_data.event_time == '0 && rsp_data.source_index == '0)
      else $error("empty result carries a time or index");

   // an accepted pop always leaves the block busy and not ready for a new item
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == OP_POP |=> !req_ready)
      else $error("ready right after a pop");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_event_merger pem_checker u_pem_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/pem_event_checker.sv */
// ----------------------------------------------------------------------------
// pem_event_checker
// Watches both channels of the periodic event merger, keeps its own copy of
// the source table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module pem_event_checker
   import pem_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           events_due
);

   logic [PER_W-1:0]  period_tab [MAX_SOURCES];
   logic [TIME_W-1:0] due_tab    [MAX_SOURCES];
   int unsigned       loaded;
   rsp_type           pending_events [$];

   // Applies one item to the table copy; fires is set when it yields a result.
   task automatic merge_step(input req_type item, output bit fires, output rsp_type ev);
      int unsigned     best;
      int unsigned     i;
      logic [TIME_W:0] sum;
      fires = 1'b0;
      ev    = '0;
      case (item.opcode)
         OP_CLEAR: loaded = 0;
         OP_LOAD: begin
            if (loaded >= MAX_SOURCES) begin
               fires       = 1'b1;
               ev.overflow = 1'b1;
            end else begin
               period_tab[loaded] = item.period;
               due_tab[loaded]    = TIME_W'(item.period);
               loaded++;
            end
         end
         OP_POP: begin
            fires = 1'b1;
            if (loaded == 0) begin
               ev.empty_res = 1'b1;
            end else begin
               // strict compare keeps the lower index on a tie
               best = 0;
               for (i = 1; i < loaded; i++)
                  if (due_tab[i] < due_tab[best]) best = i;
               ev.event_time   = due_tab[best];
               ev.source_index = best[OUT_IDX_W-1:0];
               sum = {1'b0, due_tab[best]} +
                     {{(TIME_W + 1 - PER_W){1'b0}}, period_tab[best]};
               if (sum[TIME_W]) begin
                  due_tab[best] = '1;
                  ev.overflow   = 1'b1;
               end else begin
                  due_tab[best] = sum[TIME_W-1:0];
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      bit      fires;
      rsp_type ev;
      rsp_type want;
      if (reset) begin
         loaded = 0;
         pending_events.delete();
         mismatches = 0;
      end else begin
         // result side first: a result never belongs to the item taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result: time %0d index %0d ovf %0b empty %0b",
                           $time, rsp_data.event_time, rsp_data.source_index,
                           rsp_data.overflow, rsp_data.empty_res);
            end else begin
               want = pending_events.pop_front();
               if (rsp_data.event_time !== want.event_time ||
                   rsp_data.source_index !== want.source_index ||
                   rsp_data.overflow !== want.overflow ||
                   rsp_data.empty_res !== want.empty_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch, expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                              $time, want.event_time, want.source_index, want.overflow,
                              want.empty_res, rsp_data.event_time, rsp_data.source_index,
                              rsp_data.overflow, rsp_data.empty_res);
               end
            end
         end
         if (req_valid && req_ready) begin
            merge_step(req_data, fires, ev);
            if (fires) pending_events = {pending_events, ev};
         end
      end
      events_due = pending_events.size();
   end

endmodule

/* tb/tb_periodic_event_merger.sv */
// ----------------------------------------------------------------------------
// tb_periodic_event_merger
// Drives clear, load, pop and no-op items into the merger with random gaps
// and result stalls: directed corner cases, a stretch with no idling, then
// random load/pop sequences and random item mixes.
// ----------------------------------------------------------------------------
module tb_periodic_event_merger;
   import pem_pkg::*;

   localparam int SRC_CAP      = MAX_SOURCES_DEF;
   localparam int RANDOM_ITEMS = 520;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_ready;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      events_due;
   bit      calm = 1'b0;
   int      sent = 0;

   periodic_event_merger #(.MAX_SOURCES(SRC_CAP)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pem_event_checker #(.MAX_SOURCES(SRC_CAP)) event_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .events_due (events_due)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = calm || ($urandom_range(0, 99) >= 17);
   end

   // Presents one item at a falling edge and holds it until it is taken.
   task automatic send_item(input op_type op, input logic [PER_W-1:0] per);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_data.opcode = op;
      req_data.period = per;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (op != OP_NOP) sent++;
   endtask

   // Small periods are frequent so that equal due times are common.
   function automatic logic [PER_W-1:0] draw_period();
      int unsigned pick;
      pick = $urandom_range(0, 39);
      if (pick == 0) return '0;
      if (pick < 3) return '1;
      if (pick < 20) return PER_W'($urandom_range(1, 12));
      return PER_W'($urandom_range(1, 65535));
   endfunction

   initial begin
      int n;
      int pops;
      int k;
      int base;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // pop before any load, then a no-op
      send_item(OP_POP, 16'h0000);
      send_item(OP_NOP, 16'hFFFF);
      // equal due times go to the lower index
      send_item(OP_LOAD, 16'd3);
      send_item(OP_LOAD, 16'd2);
      send_item(OP_LOAD, 16'd6);
      repeat (6) send_item(OP_POP, 16'h0000);
      // zero period fires at time zero every pop
      send_item(OP_LOAD, 16'h0000);
      repeat (2) send_item(OP_POP, 16'hFFFF);
      send_item(OP_CLEAR, 16'hFFFF);
      send_item(OP_POP, 16'h0000);
      send_item(OP_LOAD, 16'hFFFF);
      send_item(OP_LOAD, 16'h0001);
      send_item(OP_LOAD, 16'hAAAA);
      send_item(OP_LOAD, 16'h5555);
      repeat (3) send_item(OP_POP, 16'h0000);
      send_item(OP_CLEAR, 16'h0000);

      // back to back items with no idling on either side
      calm = 1'b1;
      send_item(OP_LOAD, 16'hFFFE);
      for (k = 0; k < 8; k++) send_item(OP_LOAD, draw_period());
      repeat (30) send_item(OP_POP, 16'h0000);
      send_item(OP_CLEAR, 16'h0000);
      calm = 1'b0;

      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_item(OP_CLEAR, PER_W'($urandom));
            for (k = 0; k < n; k++) send_item(OP_LOAD, draw_period());
            pops = $urandom_range(1, 2 * n + 3);
            for (k = 0; k < pops; k++) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(OP_LOAD, draw_period());
               else if ($urandom_range(0, 19) == 0)
                  send_item(OP_NOP, PER_W'($urandom));
               else
                  send_item(OP_POP, PER_W'($urandom));
            end
         end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
               send_item(op_type'($urandom_range(0, 3)), PER_W'($urandom));
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (events_due != 0) @(posedge clock);
      repeat (SRC_CAP + 64) @(posedge clock);
      if (mismatches == 0 && events_due == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
